FILE: src/bbt_pkg.sv
// Package for the block buffer table: field widths, opcodes, status codes
// and the slot entry and store-control types. No dependencies.
`timescale 1ns / 1ps

package bbt_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int IDX_W      = 5;
  localparam int DEV_W      = 8;
  localparam int BLK_W      = 32;
  localparam int REF_W      = 8;

  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_PIN     = 2'd2;
  localparam logic [1:0] OP_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_NOT_IN_USE = 2'd2;
  localparam logic [1:0] ST_COUNT      = 2'd3;

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [REF_W-1:0] refs;
  } entry_t;

  typedef struct packed {
    logic wr_en;
    logic set_use;
    logic clr_use;
  } store_ctl_t;

endpackage

FILE: src/block_buffer_table.sv
// Top level of the block buffer table: joins the request sequencer and the
// slot store. Depends on bbt_pkg, bbt_seq and bbt_store.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                        Beat payload
// request   in         start high while busy low        opcode, device, block_number, slot_handle
// result    out        result_valid_o high, one cycle   slot_index, hit, needs_read, ref_count, status
//
// A get walks the slots through one key comparator, one slot per cycle, and
// stops at the first hit; release, pin and unpin read and update the named slot.
// The result beat appears in the same cycle in which busy falls, which is also the
// first cycle in which a new request may be taken.
// Reset clears the in-use flags at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.

module block_buffer_table #(
  parameter int SlotCount = bbt_pkg::SLOT_COUNT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode_i,
  input  logic [bbt_pkg::DEV_W-1:0] device_i,
  input  logic [bbt_pkg::BLK_W-1:0] block_number_i,
  input  logic [bbt_pkg::IDX_W-1:0] slot_handle_i,
  output logic                      result_valid_o,
  output logic [bbt_pkg::IDX_W-1:0] slot_index_o,
  output logic                      hit_o,
  output logic                      needs_read_o,
  output logic [bbt_pkg::REF_W-1:0] ref_count_o,
  output logic [1:0]                status_o
);
  import bbt_pkg::*;

  localparam int AddrW = $clog2(SlotCount);

  logic [AddrW-1:0]     rd_addr;
  entry_t               rd_data;
  logic [AddrW-1:0]     wr_addr;
  entry_t               wr_data;
  store_ctl_t           ctl;
  logic [SlotCount-1:0] in_use;

  bbt_seq #(
    .SlotCount(SlotCount),
    .AddrW    (AddrW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .device_i      (device_i),
    .block_number_i(block_number_i),
    .slot_handle_i (slot_handle_i),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .ctl_o         (ctl),
    .in_use_i      (in_use),
    .result_valid_o(result_valid_o),
    .slot_index_o  (slot_index_o),
    .hit_o         (hit_o),
    .needs_read_o  (needs_read_o),
    .ref_count_o   (ref_count_o),
    .status_o      (status_o)
  );

  bbt_store #(
    .SlotCount(SlotCount),
    .AddrW    (AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .ctl_i    (ctl),
    .in_use_o (in_use)
  );

endmodule

FILE: src/bbt_store.sv
// Slot store: key and count memory with a registered read port, plus the
// in-use flags held in flip-flops. Depends on bbt_pkg.
`timescale 1ns / 1ps

module bbt_store #(
  parameter int SlotCount = 32,
  parameter int AddrW     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AddrW-1:0]     rd_addr_i,
  output bbt_pkg::entry_t      rd_data_o,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  bbt_pkg::entry_t      wr_data_i,
  input  bbt_pkg::store_ctl_t  ctl_i,
  output logic [SlotCount-1:0] in_use_o
);
  import bbt_pkg::*;

  entry_t                 mem [SlotCount];
  entry_t                 rd_q;
  logic [SlotCount-1:0]   in_use_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else if (ctl_i.set_use) begin
      in_use_q[wr_addr_i] <= 1'b1;
    end else if (ctl_i.clr_use) begin
      in_use_q[wr_addr_i] <= 1'b0;
    end
  end

  assign rd_data_o = rd_q;
  assign in_use_o  = in_use_q;

endmodule

FILE: src/bbt_seq.sv
// Request sequencer: for a get, walks the slots one per cycle through a single key
// comparator; for every request it then updates the chosen slot where allowed and registers the result.
// Depends on bbt_pkg; drives bbt_store.
`timescale 1ns / 1ps

module bbt_seq #(
  parameter int SlotCount = 32,
  parameter int AddrW     = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [bbt_pkg::DEV_W-1:0]     device_i,
  input  logic [bbt_pkg::BLK_W-1:0]     block_number_i,
  input  logic [bbt_pkg::IDX_W-1:0]     slot_handle_i,
  output logic [AddrW-1:0]              rd_addr_o,
  input  bbt_pkg::entry_t               rd_data_i,
  output logic [AddrW-1:0]              wr_addr_o,
  output bbt_pkg::entry_t               wr_data_o,
  output bbt_pkg::store_ctl_t           ctl_o,
  input  logic [SlotCount-1:0]          in_use_i,
  output logic                          result_valid_o,
  output logic [bbt_pkg::IDX_W-1:0]     slot_index_o,
  output logic                          hit_o,
  output logic                          needs_read_o,
  output logic [bbt_pkg::REF_W-1:0]     ref_count_o,
  output logic [1:0]                    status_o
);
  import bbt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SOP  = 2'd2;

  localparam logic [AddrW-1:0] LAST_IDX = AddrW'(SlotCount - 1);

  logic [1:0]       state_q, state_d;
  logic [1:0]       op_q, op_d;
  logic [DEV_W-1:0] dev_q, dev_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [IDX_W-1:0] handle_q, handle_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [AddrW-1:0] pidx_q, pidx_d;
  logic [AddrW-1:0] free_q, free_d;
  logic             free_found_q, free_found_d;

  logic             vld_q, vld_d;
  logic [IDX_W-1:0] sidx_q, sidx_d;
  logic             hit_q, hit_d;
  logic             nrd_q, nrd_d;
  logic [REF_W-1:0] refc_q, refc_d;
  logic [1:0]       st_q, st_d;

  logic             key_match;
  logic [AddrW-1:0] hidx;
  logic             handle_ok;
  logic [AddrW-1:0] claim_idx;
  logic [7:0]       pidx_ext;
  logic [7:0]       claim_ext;
  logic [REF_W-1:0] refs_inc;
  logic [REF_W-1:0] refs_dec;

  assign key_match = in_use_i[pidx_q] && (rd_data_i.dev == dev_q) && (rd_data_i.blk == blk_q);
  assign hidx      = AddrW'(handle_q);
  assign handle_ok = (32'(handle_q) < SlotCount);
  assign claim_idx = free_found_q ? free_q : pidx_q;
  assign pidx_ext  = 8'(pidx_q);
  assign claim_ext = 8'(claim_idx);
  assign refs_inc  = rd_data_i.refs + REF_W'(1);
  assign refs_dec  = rd_data_i.refs - REF_W'(1);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    dev_d        = dev_q;
    blk_d        = blk_q;
    handle_d     = handle_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    free_d       = free_q;
    free_found_d = free_found_q;
    vld_d        = 1'b0;
    sidx_d       = sidx_q;
    hit_d        = hit_q;
    nrd_d        = nrd_q;
    refc_d       = refc_q;
    st_d         = st_q;
    rd_addr_o    = idx_q;
    wr_addr_o    = pidx_q;
    wr_data_o    = rd_data_i;
    ctl_o        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d     = opcode_i;
          dev_d    = device_i;
          blk_d    = block_number_i;
          handle_d = slot_handle_i;
          if (opcode_i == OP_GET) begin
            rd_addr_o    = '0;
            idx_d        = AddrW'(1);
            pidx_d       = '0;
            free_found_d = 1'b0;
            state_d      = S_SCAN;
          end else begin
            rd_addr_o = AddrW'(slot_handle_i);
            state_d   = S_SOP;
          end
        end
      end
      S_SCAN: begin
        pidx_d = idx_q;
        idx_d  = idx_q + AddrW'(1);
        if (!free_found_q && !in_use_i[pidx_q]) begin
          free_found_d = 1'b1;
          free_d       = pidx_q;
        end
        if (key_match) begin
          vld_d   = 1'b1;
          sidx_d  = pidx_ext[IDX_W-1:0];
          hit_d   = 1'b1;
          nrd_d   = 1'b0;
          state_d = S_IDLE;
          if (rd_data_i.refs == REF_MAX) begin
            refc_d = REF_MAX;
            st_d   = ST_COUNT;
          end else begin
            ctl_o.wr_en       = 1'b1;
            wr_addr_o         = pidx_q;
            wr_data_o.dev     = dev_q;
            wr_data_o.blk     = blk_q;
            wr_data_o.refs    = refs_inc;
            refc_d            = refs_inc;
            st_d              = ST_OK;
          end
        end else if (pidx_q == LAST_IDX) begin
          vld_d   = 1'b1;
          hit_d   = 1'b0;
          state_d = S_IDLE;
          if (free_found_q || !in_use_i[pidx_q]) begin
            ctl_o.wr_en    = 1'b1;
            ctl_o.set_use  = 1'b1;
            wr_addr_o      = claim_idx;
            wr_data_o.dev  = dev_q;
            wr_data_o.blk  = blk_q;
            wr_data_o.refs = REF_W'(1);
            sidx_d         = claim_ext[IDX_W-1:0];
            nrd_d          = 1'b1;
            refc_d         = REF_W'(1);
            st_d           = ST_OK;
          end else begin
            sidx_d = '0;
            nrd_d  = 1'b0;
            refc_d = '0;
            st_d   = ST_FULL;
          end
        end
      end
      S_SOP: begin
        vld_d     = 1'b1;
        sidx_d    = handle_q;
        hit_d     = 1'b0;
        nrd_d     = 1'b0;
        wr_addr_o = hidx;
        state_d   = S_IDLE;
        if (!(handle_ok && in_use_i[hidx])) begin
          refc_d = '0;
          st_d   = ST_NOT_IN_USE;
        end else if (op_q == OP_PIN) begin
          if (rd_data_i.refs == REF_MAX) begin
            refc_d = REF_MAX;
            st_d   = ST_COUNT;
          end else begin
            ctl_o.wr_en    = 1'b1;
            wr_data_o.refs = refs_inc;
            refc_d         = refs_inc;
            st_d           = ST_OK;
          end
        end else begin
          if (rd_data_i.refs == '0) begin
            refc_d = '0;
            st_d   = ST_COUNT;
          end else begin
            ctl_o.wr_en    = 1'b1;
            ctl_o.clr_use  = (op_q == OP_RELEASE) && (refs_dec == '0);
            wr_data_o.refs = refs_dec;
            refc_d         = refs_dec;
            st_d           = ST_OK;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    dev_q        <= dev_d;
    blk_q        <= blk_d;
    handle_q     <= handle_d;
    idx_q        <= idx_d;
    pidx_q       <= pidx_d;
    free_q       <= free_d;
    free_found_q <= free_found_d;
    sidx_q       <= sidx_d;
    hit_q        <= hit_d;
    nrd_q        <= nrd_d;
    refc_q       <= refc_d;
    st_q         <= st_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = vld_q;
  assign slot_index_o   = sidx_q;
  assign hit_o          = hit_q;
  assign needs_read_o   = nrd_q;
  assign ref_count_o    = refc_q;
  assign status_o       = st_q;

endmodule

FILE: tb/sv/bbt_checker.sv
// Scoreboard for the block buffer table: keeps its own slot state, predicts
// one reply per accepted request beat and compares every reply beat.
// Depends on bbt_pkg.
`timescale 1ns / 1ps

module bbt_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                opcode_i,
  input  logic [bbt_pkg::DEV_W-1:0] device_i,
  input  logic [bbt_pkg::BLK_W-1:0] block_number_i,
  input  logic [bbt_pkg::IDX_W-1:0] slot_handle_i,
  input  logic                      result_valid_i,
  input  logic [bbt_pkg::IDX_W-1:0] slot_index_i,
  input  logic                      hit_i,
  input  logic                      needs_read_i,
  input  logic [bbt_pkg::REF_W-1:0] ref_count_i,
  input  logic [1:0]                status_i,
  output int                        pending_o,
  output int                        errors_o
);
  import bbt_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             hit;
    logic             rd;
    logic [REF_W-1:0] refs;
    logic [1:0]       status;
  } reply_t;

  logic   slot_used [SLOT_COUNT];
  entry_t slot_entry [SLOT_COUNT];
  reply_t replies_due [$];
  int     errors = 0;

  function automatic reply_t serve_request(input logic [1:0] op, input logic [DEV_W-1:0] dev,
                                           input logic [BLK_W-1:0] blk,
                                           input logic [IDX_W-1:0] handle);
    reply_t r;
    int     s;
    r = '0;
    if (op == OP_GET) begin
      for (s = 0; s < SLOT_COUNT; s++) begin
        if (slot_used[s] && slot_entry[s].dev == dev && slot_entry[s].blk == blk) begin
          r.idx = IDX_W'(s);
          r.hit = 1'b1;
          if (slot_entry[s].refs == REF_MAX) begin
            r.refs   = REF_MAX;
            r.status = ST_COUNT;
          end else begin
            slot_entry[s].refs = slot_entry[s].refs + REF_W'(1);
            r.refs   = slot_entry[s].refs;
            r.status = ST_OK;
          end
          return r;
        end
      end
      for (s = 0; s < SLOT_COUNT; s++) begin
        if (!slot_used[s]) begin
          slot_used[s]       = 1'b1;
          slot_entry[s].dev  = dev;
          slot_entry[s].blk  = blk;
          slot_entry[s].refs = REF_W'(1);
          r.idx    = IDX_W'(s);
          r.rd     = 1'b1;
          r.refs   = REF_W'(1);
          r.status = ST_OK;
          return r;
        end
      end
      r.status = ST_FULL;
      return r;
    end
    s = int'(handle);
    r.idx = handle;
    if (s >= SLOT_COUNT || !slot_used[s]) begin
      r.status = ST_NOT_IN_USE;
      return r;
    end
    if (op == OP_PIN) begin
      if (slot_entry[s].refs == REF_MAX) begin
        r.refs   = REF_MAX;
        r.status = ST_COUNT;
        return r;
      end
      slot_entry[s].refs = slot_entry[s].refs + REF_W'(1);
    end else begin
      if (slot_entry[s].refs == '0) begin
        r.status = ST_COUNT;
        return r;
      end
      slot_entry[s].refs = slot_entry[s].refs - REF_W'(1);
      if (op == OP_RELEASE && slot_entry[s].refs == '0) begin
        slot_used[s] = 1'b0;
      end
    end
    r.refs   = slot_entry[s].refs;
    r.status = ST_OK;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_used[s]       = 1'b0;
        slot_entry[s].refs = '0;
      end
      replies_due.delete();
      pending_o <= 0;
      errors_o  <= errors;
    end else begin
      if (result_valid_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: reply beat with none expected, actual slot %0d status %0d",
                   $time, slot_index_i, status_i);
          errors++;
        end else begin
          want = replies_due.pop_front();
          check_field("slot_index", 32'(want.idx), 32'(slot_index_i));
          check_field("hit", 32'(want.hit), 32'(hit_i));
          check_field("needs_read", 32'(want.rd), 32'(needs_read_i));
          check_field("ref_count", 32'(want.refs), 32'(ref_count_i));
          check_field("status", 32'(want.status), 32'(status_i));
        end
      end
      if (start_i && !busy_i) begin
        replies_due.push_back(serve_request(opcode_i, device_i, block_number_i,
                                            slot_handle_i));
      end
      pending_o <= replies_due.size();
      errors_o  <= errors;
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the block buffer table testbench: clock, reset, request stimulus
// with random gaps, a stall watchdog and the verdict.
// Depends on bbt_pkg, block_buffer_table and bbt_checker.
`timescale 1ns / 1ps

module tb_top;
  import bbt_pkg::*;

  localparam int RUN_ITEMS   = 1500;
  localparam int POOL_SIZE   = 48;
  localparam int STALL_LIMIT = 2000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       opcode;
  logic [DEV_W-1:0] device;
  logic [BLK_W-1:0] block_number;
  logic [IDX_W-1:0] slot_handle;
  logic             result_valid;
  logic [IDX_W-1:0] slot_index;
  logic             hit;
  logic             needs_read;
  logic [REF_W-1:0] ref_count;
  logic [1:0]       status;
  int               pending;
  int               errors;

  logic [DEV_W-1:0] pool_dev [POOL_SIZE];
  logic [BLK_W-1:0] pool_blk [POOL_SIZE];
  int               beats_sent = 0;
  int               idle_cycles = 0;
  bit               quiet = 1'b0;

  block_buffer_table dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode),
    .device_i       (device),
    .block_number_i (block_number),
    .slot_handle_i  (slot_handle),
    .result_valid_o (result_valid),
    .slot_index_o   (slot_index),
    .hit_o          (hit),
    .needs_read_o   (needs_read),
    .ref_count_o    (ref_count),
    .status_o       (status)
  );

  bbt_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i       (opcode),
    .device_i       (device),
    .block_number_i (block_number),
    .slot_handle_i  (slot_handle),
    .result_valid_i (result_valid),
    .slot_index_i   (slot_index),
    .hit_i          (hit),
    .needs_read_i   (needs_read),
    .ref_count_i    (ref_count),
    .status_i       (status),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [IDX_W-1:0] pick_handle();
    if ($urandom_range(9) < 7) return IDX_W'($urandom_range(15));
    return IDX_W'($urandom);
  endfunction

  task automatic issue(input logic [1:0] op, input logic [DEV_W-1:0] dev,
                       input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] h);
    start        <= 1'b1;
    opcode       <= op;
    device       <= dev;
    block_number <= blk;
    slot_handle  <= h;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  task automatic rest(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send(input logic [1:0] op, input logic [DEV_W-1:0] dev,
                      input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] h);
    issue(op, dev, blk, h);
    rest(pick_gap());
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic issue_collect(input logic [1:0] op, input logic [DEV_W-1:0] dev,
                               input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] h,
                               output logic [IDX_W-1:0] idx, output logic [1:0] st);
    issue(op, dev, blk, h);
    start <= 1'b0;
    do @(posedge clk); while (!result_valid);
    idx = slot_index;
    st  = status;
  endtask

  // Drives one slot up to the count ceiling, hits it there, unpins it once, then
  // releases it until it is freed and one release beyond.
  task automatic saturate_slot(input int k);
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] got;
    logic [1:0]       st;
    int               n;
    issue_collect(OP_GET, pool_dev[k], pool_blk[k], IDX_W'($urandom), idx, st);
    if (st != ST_OK) return;
    n = 0;
    do begin
      issue_collect(OP_PIN, DEV_W'($urandom), BLK_W'($urandom), idx, got, st);
      n++;
    end while (st == ST_OK && n < 300);
    issue_collect(OP_GET, pool_dev[k], pool_blk[k], IDX_W'($urandom), got, st);
    issue_collect(OP_UNPIN, DEV_W'($urandom), BLK_W'($urandom), idx, got, st);
    n = 0;
    do begin
      issue_collect(OP_RELEASE, DEV_W'($urandom), BLK_W'($urandom), idx, got, st);
      n++;
    end while (st == ST_OK && n < 300);
  endtask

  task automatic mixed_phase(input int len);
    int         w_get;
    int         r;
    int         k;
    logic [1:0] op;
    w_get = $urandom_range(70, 15);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < w_get) begin
        k = $urandom_range(POOL_SIZE - 1);
        if ($urandom_range(9) == 0) begin
          send(OP_GET, DEV_W'($urandom), BLK_W'($urandom), IDX_W'($urandom));
        end else begin
          send(OP_GET, pool_dev[k], pool_blk[k], IDX_W'($urandom));
        end
      end else begin
        if (r < w_get + (100 - w_get) / 2) begin
          op = OP_RELEASE;
        end else if (r[0]) begin
          op = OP_PIN;
        end else begin
          op = OP_UNPIN;
        end
        send(op, DEV_W'($urandom), BLK_W'($urandom), pick_handle());
      end
    end
  endtask

  initial begin
    int  mode;
    bit  saturated_again;
    saturated_again = 1'b0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    opcode       <= OP_GET;
    device       <= '0;
    block_number <= '0;
    slot_handle  <= '0;
    pool_dev[0] = '0;
    pool_blk[0] = '0;
    pool_dev[1] = '1;
    pool_blk[1] = '1;
    for (int k = 2; k < POOL_SIZE; k++) begin
      if (k % 4 == 3) begin
        pool_dev[k] = pool_dev[k-1] ^ (DEV_W'(1) << $urandom_range(DEV_W - 1));
        pool_blk[k] = pool_blk[k-1];
      end else if (k % 2 == 1) begin
        pool_dev[k] = pool_dev[k-1];
        pool_blk[k] = pool_blk[k-1] ^ (BLK_W'(1) << $urandom_range(BLK_W - 1));
      end else begin
        pool_dev[k] = DEV_W'($urandom);
        pool_blk[k] = BLK_W'($urandom);
      end
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(OP_RELEASE, '0, '0, '0);
    send(OP_PIN, '1, '1, '1);
    send(OP_UNPIN, '0, '0, IDX_W'(5));
    send(OP_GET, '0, '0, '1);
    send(OP_GET, '1, '1, '0);
    send(OP_GET, '0, '0, '0);
    send(OP_GET, '0, BLK_W'(1), '0);
    send(OP_GET, DEV_W'(1), '0, '0);
    send(OP_PIN, '0, '0, IDX_W'(1));
    send(OP_UNPIN, '0, '0, IDX_W'(1));
    send(OP_UNPIN, '0, '0, IDX_W'(1));
    send(OP_UNPIN, '0, '0, IDX_W'(1));
    send(OP_RELEASE, '0, '0, IDX_W'(1));
    send(OP_GET, '1, '1, '0);
    send(OP_RELEASE, '0, '0, IDX_W'(1));
    send(OP_RELEASE, '0, '0, IDX_W'(1));
    send(OP_GET, DEV_W'(7), 32'h8000_0000, '0);
    send(OP_RELEASE, '1, '1, '0);
    send(OP_RELEASE, '1, '1, '0);
    saturate_slot(0);

    while (beats_sent < RUN_ITEMS) begin
      mode  = $urandom_range(99);
      quiet = ($urandom_range(4) == 0);
      if (mode < 6 && !saturated_again) begin
        saturated_again = 1'b1;
        saturate_slot($urandom_range(POOL_SIZE - 1));
      end else if (mode < 25) begin
        repeat ($urandom_range(40, 34)) begin
          send(OP_GET, DEV_W'($urandom), BLK_W'($urandom), IDX_W'($urandom));
        end
      end else if (mode < 35) begin
        drain_replies();
        mixed_phase($urandom_range(120, 40));
      end else begin
        mixed_phase($urandom_range(120, 40));
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/bbt_pkg.sv
src/bbt_store.sv
src/bbt_seq.sv
src/block_buffer_table.sv
tb/sv/bbt_checker.sv
tb/sv/tb_top.sv
